### src/ifs_pkg.sv
`default_nettype none

package ifs_pkg;

   // table geometry
   localparam int MAX_TRANSFORMS = 8;
   localparam int COEFS_PER      = 6;
   localparam int ROW_W          = (MAX_TRANSFORMS > 1) ? $clog2(MAX_TRANSFORMS) : 1;

   // fixed point format
   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 64 - FRAC_BITS + 2;

   // operation codes
   localparam logic OP_STEP = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // coefficient slot codes
   localparam logic [2:0] SLOT_A = 3'd0;
   localparam logic [2:0] SLOT_B = 3'd1;
   localparam logic [2:0] SLOT_C = 3'd2;
   localparam logic [2:0] SLOT_D = 3'd3;
   localparam logic [2:0] SLOT_E = 3'd4;
   localparam logic [2:0] SLOT_F = 3'd5;

   // word limits
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

   // reset constants, saturated to the word range
   localparam logic signed [63:0] HUNDRED_WIDE = 64'sd100 <<< FRAC_BITS;
   localparam logic signed [31:0] FIX_ONE      = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] FIX_HUNDRED  =
      (HUNDRED_WIDE > 64'sd2147483647) ? WORD_MAX : HUNDRED_WIDE[31:0];
   localparam logic signed [31:0] FIX_NEG_HUNDRED =
      (HUNDRED_WIDE > 64'sd2147483648) ? WORD_MIN : 32'(-HUNDRED_WIDE);

   typedef struct packed {
      logic               operation;
      logic [2:0]         transform_index;
      logic [2:0]         coef_slot;
      logic signed [31:0] coef_value;
   } ifs_req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [2:0]         used_transform;
      logic signed [31:0] bound_min_x;
      logic signed [31:0] bound_max_x;
      logic signed [31:0] bound_min_y;
      logic signed [31:0] bound_max_y;
   } ifs_rsp_type;

   // one transform's coefficients
   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [31:0] d;
      logic signed [31:0] e;
      logic signed [31:0] f;
   } ifs_coef_row_type;

   // table write request
   typedef struct packed {
      logic               en;
      logic [ROW_W-1:0]   row;
      logic [2:0]         slot;
      logic signed [31:0] value;
   } ifs_coef_wr_type;

   // step request to the point core
   typedef struct packed {
      logic       en;
      logic [2:0] index;
   } ifs_step_type;

endpackage

`default_nettype wire

### src/ifs_coef_table.sv
`default_nettype none

module ifs_coef_table
   import ifs_pkg::*;
(
   input  wire logic             clock,
   input  wire ifs_coef_wr_type  wr,
   input  wire logic [ROW_W-1:0] rd_row,
   output ifs_coef_row_type      rd_data
);

   // one row of six words per transform, no reset
   ifs_coef_row_type coef_ff [MAX_TRANSFORMS];

   // single word write into the addressed row
   always_ff @(posedge clock) begin
      if (wr.en) begin
         unique case (wr.slot)
            SLOT_A:  coef_ff[wr.row].a <= wr.value;
            SLOT_B:  coef_ff[wr.row].b <= wr.value;
            SLOT_C:  coef_ff[wr.row].c <= wr.value;
            SLOT_D:  coef_ff[wr.row].d <= wr.value;
            SLOT_E:  coef_ff[wr.row].e <= wr.value;
            SLOT_F:  coef_ff[wr.row].f <= wr.value;
            default: ;
         endcase
      end
   end

   // row select for the step in flight
   assign rd_data = coef_ff[rd_row];

endmodule

`default_nettype wire

### src/ifs_step_core.sv
`default_nettype none

module ifs_step_core
   import ifs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ifs_step_type     step,
   input  wire ifs_coef_row_type coef,
   output ifs_rsp_type           rsp
);

   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(WORD_MAX);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(WORD_MIN);

   logic signed [31:0] cur_x_ff, cur_x_in;
   logic signed [31:0] cur_y_ff, cur_y_in;
   logic signed [31:0] low_x_ff, low_x_in;
   logic signed [31:0] high_x_ff, high_x_in;
   logic signed [31:0] low_y_ff, low_y_in;
   logic signed [31:0] high_y_ff, high_y_in;
   logic               index_ok;
   logic signed [31:0] next_x;
   logic signed [31:0] next_y;

   // k1*u + k2*v + k3, products floored, sum saturated
   function automatic logic signed [31:0] affine_word(
      input logic signed [31:0] k1,
      input logic signed [31:0] k2,
      input logic signed [31:0] k3,
      input logic signed [31:0] u,
      input logic signed [31:0] v
   );
      logic signed [63:0]      p1;
      logic signed [63:0]      p2;
      logic signed [SUM_W-1:0] s;
      p1 = k1 * u;
      p2 = k2 * v;
      s  = SUM_W'(p1 >>> FRAC_BITS) + SUM_W'(p2 >>> FRAC_BITS) + SUM_W'(k3);
      if (s > SUM_MAX) begin
         return WORD_MAX;
      end else if (s < SUM_MIN) begin
         return WORD_MIN;
      end
      return s[31:0];
   endfunction

   assign index_ok = (32'(step.index) < MAX_TRANSFORMS);
   assign next_x   = affine_word(coef.a, coef.b, coef.e, cur_x_ff, cur_y_ff);
   assign next_y   = affine_word(coef.c, coef.d, coef.f, cur_x_ff, cur_y_ff);

   // running bounds including the current point
   always_comb begin
      low_x_in  = (cur_x_ff < low_x_ff)  ? cur_x_ff : low_x_ff;
      high_x_in = (cur_x_ff > high_x_ff) ? cur_x_ff : high_x_ff;
      low_y_in  = (cur_y_ff < low_y_ff)  ? cur_y_ff : low_y_ff;
      high_y_in = (cur_y_ff > high_y_ff) ? cur_y_ff : high_y_ff;
   end

   // point moves only for a transform that exists
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (index_ok) begin
         cur_x_in = next_x;
         cur_y_in = next_y;
      end
   end

   // point and bounds state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= FIX_ONE;
         cur_y_ff  <= FIX_ONE;
         low_x_ff  <= FIX_HUNDRED;
         low_y_ff  <= FIX_HUNDRED;
         high_x_ff <= FIX_NEG_HUNDRED;
         high_y_ff <= FIX_NEG_HUNDRED;
      end else if (step.en) begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         low_x_ff  <= low_x_in;
         low_y_ff  <= low_y_in;
         high_x_ff <= high_x_in;
         high_y_ff <= high_y_in;
      end
   end

   // result payload for this step
   always_comb begin
      rsp.point_x        = cur_x_ff;
      rsp.point_y        = cur_y_ff;
      rsp.used_transform = step.index;
      rsp.bound_min_x    = low_x_in;
      rsp.bound_max_x    = high_x_in;
      rsp.bound_min_y    = low_y_in;
      rsp.bound_max_y    = high_y_in;
   end

endmodule

`default_nettype wire

### src/affine_ifs_chaos_game_step_unit.sv
// Chaos-game step unit for an affine iterated function system in signed
// Q16.16. Load transactions write one coefficient (a..f) of one of eight
// transforms and return nothing; step transactions return the current point,
// the chosen transform and the running bounding box, then move the point to
// (a*x+b*y+e, c*x+d*y+f) with floored products and a saturated sum. An
// accepted transaction is held in the input register and its result is then
// offered on the rsp channel from the result register; a new transaction is
// taken every cycle unless a step waits on a stalled rsp channel, the rate
// being set by the point feedback through four 32x32 multipliers and the
// saturating adders, which is combinational. Loads take effect for the very
// next step. Stepping with a coefficient never loaded since reset gives an
// undefined point. The point resets to (1,1), the bounds to min 100 and max -100.
`default_nettype none

module affine_ifs_chaos_game_step_unit
   import ifs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire ifs_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ifs_rsp_type      rsp_data
);

   ifs_req_type      stage_ff, stage_in;
   logic             stage_vld_ff, stage_vld_in;
   logic             rsp_vld_ff, rsp_vld_in;
   ifs_rsp_type      rsp_data_ff, rsp_data_in;
   logic             out_free;
   logic             advance;
   logic             step_fire;
   logic             load_fire;
   ifs_coef_wr_type  coef_wr;
   ifs_coef_row_type coef_row;
   ifs_step_type     step;
   ifs_rsp_type      core_rsp;

   // input stage handshake
   assign out_free  = !rsp_vld_ff || rsp_ready;
   assign advance   = stage_vld_ff && ((stage_ff.operation == OP_LOAD) || out_free);
   assign step_fire = advance && (stage_ff.operation == OP_STEP);
   assign load_fire = advance && (stage_ff.operation == OP_LOAD);
   assign req_ready = !stage_vld_ff || advance;

   always_comb begin
      stage_vld_in = stage_vld_ff;
      stage_in     = stage_ff;
      if (req_ready) begin
         stage_vld_in = req_valid;
         stage_in     = req_data;
      end
   end

   // table write for a load that names a real transform
   always_comb begin
      coef_wr.en    = load_fire && (32'(stage_ff.transform_index) < MAX_TRANSFORMS);
      coef_wr.row   = ROW_W'(stage_ff.transform_index);
      coef_wr.slot  = stage_ff.coef_slot;
      coef_wr.value = stage_ff.coef_value;
   end

   assign step.en    = step_fire;
   assign step.index = stage_ff.transform_index;

   ifs_coef_table u_table (
      .clock   (clock),
      .wr      (coef_wr),
      .rd_row  (ROW_W'(stage_ff.transform_index)),
      .rd_data (coef_row)
   );

   ifs_step_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .coef  (coef_row),
      .rsp   (core_rsp)
   );

   // result register
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (step_fire) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = core_rsp;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/ifs_checker.sv
`default_nettype none

module ifs_checker
   import ifs_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire ifs_rsp_type rsp_data
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // x bounds enclose the reported point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.bound_min_x) <= $signed(rsp_data.point_x)) &&
                    ($signed(rsp_data.point_x) <= $signed(rsp_data.bound_max_x)))
      else $error("x bounds exclude point");

   // y bounds enclose the reported point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_data.bound_min_y) <= $signed(rsp_data.point_y)) &&
                    ($signed(rsp_data.point_y) <= $signed(rsp_data.bound_max_y)))
      else $error("y bounds exclude point");

endmodule

bind affine_ifs_chaos_game_step_unit ifs_checker u_ifs_checker (.*);

`default_nettype wire
